### design/sra_pkg.sv
// Shared types and constants for the sensor SPI read arbiter.
package sra_pkg;

    localparam int unsigned NUM_SRC   = 3;
    localparam int unsigned LEN_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [NUM_SRC-1:0]   t_flags;
    typedef logic [1:0]           t_src;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_READY    = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_CONSUME  = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    localparam t_src SRC_GYRO  = 2'd0;
    localparam t_src SRC_ACCEL = 2'd1;
    localparam t_src SRC_TEMP  = 2'd2;

    localparam t_cfg_idx CFG_GYRO_LEN  = 2'd0;
    localparam t_cfg_idx CFG_ACCEL_LEN = 2'd1;
    localparam t_cfg_idx CFG_TEMP_LEN  = 2'd2;

    localparam t_len RST_GYRO_LEN  = 8'd8;
    localparam t_len RST_ACCEL_LEN = 8'd9;
    localparam t_len RST_TEMP_LEN  = 8'd4;

    typedef struct packed {
        t_len gyro;
        t_len accel;
        t_len temp;
    } t_len_set;

    typedef struct packed {
        logic   start_res;
        t_src   start_source;
        t_len   start_length;
        logic   gyro_select_low;
        logic   accel_select_low;
        t_flags done_flags;
        t_flags consumed_flags;
        logic   notify;
    } t_result;

endpackage

### design/sra_in_if.sv
// Event word channel into the arbiter.
interface sra_in_if;
    import sra_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_src  source;
    logic  dma_busy;

    modport src (output valid, kind, source, dma_busy, input ready);
    modport snk (input valid, kind, source, dma_busy, output ready);
endinterface

### design/sra_out_if.sv
// Result word channel out of the arbiter.
interface sra_out_if;
    import sra_pkg::*;

    logic   valid;
    logic   ready;
    logic   start_res;
    t_src   start_source;
    t_len   start_length;
    logic   gyro_select_low;
    logic   accel_select_low;
    t_flags done_flags;
    t_flags consumed_flags;
    logic   notify;

    modport src (
        output valid, start_res, start_source, start_length, gyro_select_low,
               accel_select_low, done_flags, consumed_flags, notify,
        input  ready
    );
    modport snk (
        input  valid, start_res, start_source, start_length, gyro_select_low,
               accel_select_low, done_flags, consumed_flags, notify,
        output ready
    );
endinterface

### design/sensor_spi_read_arbiter.sv
// Top level of the sensor SPI read arbiter: input register, core, result register.
// One event word is accepted per cycle while input ready is high. The word is captured in
// an input register, and the flag update and gyro/accel/temp priority choice resolve into
// the result register once that register is empty or its word is taken. Sustained rate is
// one word per clock while results are taken, set by the flag update loop in the core.
// While a result word waits, the empty input register still takes one word. Further input
// stalls until the result word is taken, and input ready follows output ready
// combinationally. The user must write length registers through the plain write port
// only while no word is in flight; the block itself does not enforce this.
module sensor_spi_read_arbiter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sra_in_if.snk               i_in,
    sra_out_if.src              o_out,
    input  logic                i_cfg_we,
    input  sra_pkg::t_cfg_idx   i_cfg_idx,
    input  sra_pkg::t_len       i_cfg_data
);
    import sra_pkg::*;

    t_len_set r_len;
    logic     r_in_vld;
    t_kind    r_kind;
    t_src     r_source;
    logic     r_busy;
    logic     r_out_vld;
    t_result  r_res;
    t_result  w_res;
    logic     w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len.gyro  <= RST_GYRO_LEN;
            r_len.accel <= RST_ACCEL_LEN;
            r_len.temp  <= RST_TEMP_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GYRO_LEN:  r_len.gyro  <= i_cfg_data;
                CFG_ACCEL_LEN: r_len.accel <= i_cfg_data;
                CFG_TEMP_LEN:  r_len.temp  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind   <= i_in.kind;
            r_source <= i_in.source;
            r_busy   <= i_in.dma_busy;
        end
    end

    sra_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_adv),
        .i_kind     (r_kind),
        .i_source   (r_source),
        .i_dma_busy (r_busy),
        .i_len      (r_len),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.start_res        = r_res.start_res;
    assign o_out.start_source     = r_res.start_source;
    assign o_out.start_length     = r_res.start_length;
    assign o_out.gyro_select_low  = r_res.gyro_select_low;
    assign o_out.accel_select_low = r_res.accel_select_low;
    assign o_out.done_flags       = r_res.done_flags;
    assign o_out.consumed_flags   = r_res.consumed_flags;
    assign o_out.notify           = r_res.notify;

`ifndef SYNTHESIS
    a_idle_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.start_res) |->
            (o_out.start_source == SRC_GYRO && o_out.start_length == '0))
        else $error("start fields set without a started read");

    a_notify_gyro_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.notify) |-> o_out.done_flags[SRC_GYRO])
        else $error("notify without gyro done");

    a_consume_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.consumed_flags != '0)) |->
            (o_out.done_flags == '0 && !o_out.start_res))
        else $error("consume left done flags or started a read");

    a_result_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("processed word produced no result");
`endif

endmodule

### design/sra_core.sv
// Flag state and fixed-priority read arbitration for one event word.
module sra_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  sra_pkg::t_kind    i_kind,
    input  sra_pkg::t_src     i_source,
    input  logic              i_dma_busy,
    input  sra_pkg::t_len_set i_len,
    output sra_pkg::t_result  o_res
);
    import sra_pkg::*;

    t_flags    r_ready, n_ready;
    t_flags    r_xfer,  n_xfer;
    t_flags    r_done,  n_done;
    logic [1:0] r_sel,  n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
            r_xfer  <= '0;
            r_done  <= '0;
            r_sel   <= '0;
        end else if (i_step) begin
            r_ready <= n_ready;
            r_xfer  <= n_xfer;
            r_done  <= n_done;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        t_flags     rf;
        t_flags     tf;
        t_flags     df;
        logic [1:0] sf;
        t_flags     src_bit;
        logic       arb;
        logic       found;
        t_src       win;
        t_len       len;
        t_flags     cons;
        logic       ntf;

        rf      = r_ready;
        tf      = r_xfer;
        df      = r_done;
        sf      = r_sel;
        src_bit = '0;
        arb     = 1'b0;
        found   = 1'b0;
        win     = SRC_GYRO;
        len     = '0;
        cons    = '0;
        ntf     = 1'b0;

        case (i_kind)
            KIND_READY: begin
                if (i_source <= SRC_TEMP) begin
                    src_bit = NUM_SRC'(1) << i_source;
                end
                rf  = rf | src_bit;
                arb = 1'b1;
            end
            KIND_COMPLETE: begin
                if (tf[SRC_GYRO]) begin
                    sf[0] = 1'b0;
                end
                if (tf[SRC_ACCEL] || tf[SRC_TEMP]) begin
                    sf[1] = 1'b0;
                end
                df  = df | tf;
                tf  = '0;
                arb = 1'b1;
            end
            KIND_CONSUME: begin
                cons = df;
                df   = '0;
            end
            default: begin
            end
        endcase

        if (arb && !i_dma_busy) begin
            for (int s = 0; s < NUM_SRC; s++) begin
                if (!found && rf[s] && ((tf & ~(NUM_SRC'(1) << s)) == '0)) begin
                    found = 1'b1;
                    win   = t_src'(s);
                end
            end
            if (found) begin
                rf[win] = 1'b0;
                tf[win] = 1'b1;
                case (win)
                    SRC_GYRO: begin
                        sf[0] = 1'b1;
                        len   = i_len.gyro;
                    end
                    SRC_ACCEL: begin
                        sf[1] = 1'b1;
                        len   = i_len.accel;
                    end
                    default: begin
                        sf[1] = 1'b1;
                        len   = i_len.temp;
                    end
                endcase
            end
        end

        if (i_kind == KIND_COMPLETE) begin
            ntf = df[SRC_GYRO];
        end

        n_ready = rf;
        n_xfer  = tf;
        n_done  = df;
        n_sel   = sf;

        o_res.start_res        = found;
        o_res.start_source     = found ? win : SRC_GYRO;
        o_res.start_length     = len;
        o_res.gyro_select_low  = sf[0];
        o_res.accel_select_low = sf[1];
        o_res.done_flags       = df;
        o_res.consumed_flags   = cons;
        o_res.notify           = ntf;
    end

`ifndef SYNTHESIS
    a_xfer_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_xfer))
        else $error("more than one source in transfer");
`endif

endmodule
